[src/dfs_pkg.sv]
`default_nettype none

package dfs_pkg;

    // Fixed widths of the payload and the line state
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned POS_W  = 7;
    localparam int unsigned SEL_W  = 64;
    localparam int unsigned IDX_W  = 6;
    localparam int unsigned CFG_IDX_W = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECTED  = 2'd2;

    // Byte codes
    localparam logic [BYTE_W-1:0] NL_BYTE  = 8'h0A;
    localparam logic [BYTE_W-1:0] TAB_BYTE = 8'h09;

    // Depth of the queue between front and back
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One queued entry: one or two result bytes caused by one input item
    typedef struct packed {
        logic              two;
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
    } t_entry;

    // Push request from front to queue
    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_push;

endpackage

`default_nettype wire

[src/dfs_front.sv]
`default_nettype none

module dfs_front #(
    parameter int unsigned MAX_SELECTED_POSITION = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [dfs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [dfs_pkg::SEL_W-1:0]     i_cfg_data,
    input  wire logic                          i_accept,
    input  wire logic [dfs_pkg::BYTE_W-1:0]    i_byte,
    input  wire logic                          i_end,
    output dfs_pkg::t_push                     o_push
);
    import dfs_pkg::*;

    localparam int unsigned POS_LIMIT = MAX_SELECTED_POSITION + 1;

    logic              r_char_mode;
    logic [BYTE_W-1:0] r_delim;
    logic [SEL_W-1:0]  r_sel;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_efc, n_efc;

    logic [POS_W-1:0]  pos_adv;
    logic [IDX_W-1:0]  idx_cur, idx_adv;
    logic              sel_cur, sel_adv;
    logic              is_nl, is_delim, efc_delim;
    logic              has_a, nl_app;
    logic [BYTE_W-1:0] a_byte;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers; other indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_mode <= 1'b0;
            r_delim     <= TAB_BYTE;
            r_sel       <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CHAR_MODE: r_char_mode <= i_cfg_data[0];
                CFG_DELIMITER: r_delim     <= i_cfg_data[BYTE_W-1:0];
                CFG_SELECTED:  r_sel       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Test the current and the next position against the bitmap
    always_comb begin
        pos_adv = (r_pos < POS_W'(POS_LIMIT)) ? r_pos + POS_W'(1) : r_pos;
        idx_cur = IDX_W'(r_pos - POS_W'(1));
        idx_adv = IDX_W'(pos_adv - POS_W'(1));
        sel_cur = (r_pos != '0) && (r_pos <= POS_W'(MAX_SELECTED_POSITION)) && r_sel[idx_cur];
        sel_adv = (pos_adv != '0) && (pos_adv <= POS_W'(MAX_SELECTED_POSITION))
                  && r_sel[idx_adv];
    end

    // Classify the item and work out its results and the next line state
    always_comb begin
        is_nl     = (i_byte == NL_BYTE);
        is_delim  = !r_char_mode && (i_byte == r_delim);
        efc_delim = r_efc | sel_cur;
        has_a     = 1'b0;
        a_byte    = i_byte;
        nl_app    = 1'b0;
        n_pos     = r_pos;
        n_efc     = r_efc;
        if (is_nl) begin
            n_pos = POS_W'(1);
            n_efc = 1'b0;
        end else begin
            if (r_char_mode) begin
                has_a = sel_cur;
                n_pos = pos_adv;
            end else if (is_delim) begin
                n_efc  = efc_delim;
                n_pos  = pos_adv;
                has_a  = sel_adv && efc_delim;
                a_byte = r_delim;
            end else begin
                has_a = sel_cur;
            end
            if (i_end) begin
                nl_app = 1'b1;
                n_pos  = POS_W'(1);
                n_efc  = 1'b0;
            end
        end
    end

    // Build the queue entry
    always_comb begin
        o_push.push        = i_accept && (is_nl || has_a || nl_app);
        o_push.entry.two   = has_a && nl_app;
        o_push.entry.byte0 = (is_nl || !has_a) ? NL_BYTE : a_byte;
        o_push.entry.byte1 = NL_BYTE;
    end

    // Advance the line state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_W'(1);
            r_efc <= 1'b0;
        end else if (i_accept) begin
            r_pos <= n_pos;
            r_efc <= n_efc;
        end
    end

endmodule

`default_nettype wire

[src/dfs_queue.sv]
`default_nettype none

module dfs_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire dfs_pkg::t_push  i_push,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output dfs_pkg::t_entry      o_entry
);
    import dfs_pkg::*;

    t_entry               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr, r_rd;
    logic [Q_CNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd];

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.entry;
        end
    end

    // Advance pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            case ({i_push.push, i_pop})
                2'b10:   r_cnt <= r_cnt + Q_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - Q_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push.push && o_full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue pop while empty");

endmodule

`default_nettype wire

[src/dfs_back.sv]
`default_nettype none

module dfs_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_empty,
    input  wire dfs_pkg::t_entry            i_entry,
    output logic                            o_pop,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [dfs_pkg::BYTE_W-1:0]      o_byte,
    output logic                            o_last
);
    import dfs_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic              r_pend;
    logic [BYTE_W-1:0] r_pend_byte;
    logic              load;

    assign load    = !r_valid || i_ready;
    assign o_pop   = load && !r_pend && !i_empty;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

    // Load the output register from the pending second byte or the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else begin
                r_valid <= !i_empty;
                r_pend  <= !i_empty && i_entry.two;
            end
        end
    end

    // Payload of the output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_byte <= r_pend_byte;
                r_last <= 1'b1;
            end else begin
                r_byte      <= i_entry.byte0;
                r_last      <= !i_entry.two;
                r_pend_byte <= i_entry.byte1;
            end
        end
    end

    a_pend_shows_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_valid && !r_last))
        else $error("second byte pending without a shown first byte");

    a_pend_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && i_ready) |=> (r_valid && r_last && !r_pend))
        else $error("pending byte not shown after first byte taken");

endmodule

`default_nettype wire

[src/delimited_field_selector_unit.sv]
// Delimited field selector: passes on selected character positions or
// delimiter-separated fields of each line of a text byte stream.
//
// Channels:
//   s side (i_s_*): one text byte per item, tlast marks the final byte.
//   m side (o_m_*): selected bytes, inserted delimiters and newlines;
//     tlast marks the last result caused by one input byte.
//   cfg: register writes (0 char mode, 1 delimiter, 2 position bitmap),
//     always ready; write only while the block is idle.
// Path: an accepted item is queued, and its first result is then loaded
// into the output register. Throughput: one input item per cycle as long
// as results drain; an item with two results holds the output port for
// both; the four-entry queue between classifier and output stage absorbs it.
// Items that cause no result never reach the queue.
// Reset: line state returns to position 1, registers to field mode, tab
// delimiter, empty bitmap; queue and output register empty.
// Stall: a stalled receiver holds the output register; the queue fills and
// then o_s_tready drops until space frees.
`default_nettype none

module delimited_field_selector_unit #(
    parameter int unsigned MAX_SELECTED_POSITION = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // cfg channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [dfs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [dfs_pkg::SEL_W-1:0]     i_cfg_data,
    // input stream
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [7:0]                    i_s_tdata,  // [7:0] in_byte
    input  wire logic                          i_s_tlast,  // end_of_stream
    // output stream
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [7:0]                         o_m_tdata,  // [7:0] out_byte
    output logic                               o_m_tlast   // run_last
);
    import dfs_pkg::*;

    t_push  push;
    t_entry head;
    logic   q_full, q_empty, pop;

    assign o_s_tready = !q_full;

    dfs_front #(
        .MAX_SELECTED_POSITION(MAX_SELECTED_POSITION)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (i_s_tvalid && !q_full),
        .i_byte      (i_s_tdata),
        .i_end       (i_s_tlast),
        .o_push      (push)
    );

    dfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_entry (head)
    );

    dfs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_entry (head),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_byte  (o_m_tdata),
        .o_last  (o_m_tlast)
    );

endmodule

`default_nettype wire

[tb/dfs_checker.sv]
`timescale 1ns / 100ps

module dfs_checker
    import dfs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SEL_W-1:0]     i_cfg_data,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [BYTE_W-1:0]    i_s_tdata,
    input  logic                 i_s_tlast,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [BYTE_W-1:0]    i_m_tdata,
    input  logic                 i_m_tlast,
    output int                   o_pending,
    output int                   o_errors
);

    // Highest position the bitmap can pick; the counter stops one above it
    localparam int TOP_POSITION = 64;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_out_byte;

    // Bytes still owed by the block, oldest first
    t_out_byte due_bytes[$];

    // Shadow registers and line state
    logic              mode_chars;
    logic [BYTE_W-1:0] sep_byte;
    logic [SEL_W-1:0]  pick_map;
    logic [POS_W-1:0]  line_pos;
    logic              field_seen;
    int                err_total = 0;

    initial begin
        o_pending = 0;
        o_errors  = 0;
    end

    function automatic logic picked(input logic [POS_W-1:0] pos);
        if (pos < 1 || pos > TOP_POSITION) return 1'b0;
        return pick_map[pos - 1];
    endfunction

    task automatic restart_line();
        line_pos   = 1;
        field_seen = 1'b0;
    endtask

    // Saturate one above the last position the bitmap covers
    task automatic advance_pos();
        if (line_pos <= TOP_POSITION) line_pos = line_pos + 1'b1;
    endtask

    task automatic log_error(input string msg);
        err_total++;
        if (err_total <= 10) $display("%0t dfs check: %s", $time, msg);
    endtask

    // Work out the bytes one input item releases and queue them
    task automatic select_from_line(input logic [BYTE_W-1:0] b, input logic eos);
        logic [BYTE_W-1:0] outs[$];
        if (b == NL_BYTE) begin
            outs.push_back(NL_BYTE);
            restart_line();
        end else begin
            if (mode_chars) begin
                if (picked(line_pos)) outs.push_back(b);
                advance_pos();
            end else if (b == sep_byte) begin
                // close this field, then emit a separator if the next one
                // is picked and an earlier field was already shown
                if (picked(line_pos)) field_seen = 1'b1;
                advance_pos();
                if (picked(line_pos) && field_seen) outs.push_back(sep_byte);
            end else if (picked(line_pos)) begin
                outs.push_back(b);
            end
            // unterminated final line still gets its newline
            if (eos) begin
                outs.push_back(NL_BYTE);
                restart_line();
            end
        end
        foreach (outs[k])
            due_bytes.push_back('{data: outs[k], last: (k == outs.size() - 1)});
    endtask

    // Track writes, compare results, predict new items
    always @(posedge i_clk) begin
        t_out_byte want;
        if (!i_rst_n) begin
            mode_chars = 1'b0;
            sep_byte   = TAB_BYTE;
            pick_map   = '0;
            restart_line();
            due_bytes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CHAR_MODE: mode_chars = i_cfg_data[0];
                    CFG_DELIMITER: sep_byte   = i_cfg_data[BYTE_W-1:0];
                    CFG_SELECTED:  pick_map   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (due_bytes.size() == 0) begin
                    log_error($sformatf("unexpected item byte=%h last=%b",
                                        i_m_tdata, i_m_tlast));
                end else begin
                    want = due_bytes.pop_front();
                    if (i_m_tdata !== want.data)
                        log_error($sformatf("out_byte exp %h got %h",
                                            want.data, i_m_tdata));
                    if (i_m_tlast !== want.last)
                        log_error($sformatf("run_last exp %b got %b (byte %h)",
                                            want.last, i_m_tlast, want.data));
                end
            end
            if (i_s_tvalid && i_s_tready) select_from_line(i_s_tdata, i_s_tlast);
        end
        o_pending <= due_bytes.size();
        o_errors  <= err_total;
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import dfs_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int IDLE_PCT      = 36;

    // Index past the last register; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [SEL_W-1:0]     i_cfg_data  = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic [BYTE_W-1:0]    i_s_tdata   = '0;
    logic                 i_s_tlast   = 1'b0;
    logic                 i_m_tready  = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [BYTE_W-1:0]    o_m_tdata;
    logic                 o_m_tlast;

    int                   pending;
    int                   errors;
    int                   item_count   = 0;
    int                   quiet_cycles = 0;
    bit                   steady       = 1'b0;
    logic [BYTE_W-1:0]    cur_sep      = TAB_BYTE;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    delimited_field_selector_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    dfs_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tlast   (o_m_tlast),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // Receiver: stall at random except during the steady stretch
    always @(posedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Count cycles with no item moving on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("delimited_field_selector_unit: mismatch");
        $finish;
    end

    // Offer one byte, idling first at random; tvalid stays high on return
    task automatic send_item(input logic [BYTE_W-1:0] b, input logic eos);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= eos;
        do @(posedge i_clk); while (!o_s_tready);
        item_count++;
    endtask

    // Hold the input, wait for every owed byte, then let the pipe settle
    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SEL_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Rewrite all registers while idle; unused bits carry noise
    task automatic configure(input logic cm, input logic [BYTE_W-1:0] dl,
                             input logic [SEL_W-1:0] sel);
        logic [SEL_W-1:0] noise;
        noise = {$urandom, $urandom};
        drain();
        put_reg(CFG_UNUSED, {$urandom, $urandom});
        put_reg(CFG_CHAR_MODE, {noise[SEL_W-1:1], cm});
        put_reg(CFG_DELIMITER, {noise[SEL_W-1:BYTE_W], dl});
        put_reg(CFG_SELECTED, sel);
        i_cfg_valid <= 1'b0;
        cur_sep = dl;
    endtask

    // One random line: mostly well formed, some raw noise
    task automatic send_line();
        int               len;
        int               sep_pct;
        int               ending;
        logic [BYTE_W-1:0] b;
        if ($urandom_range(99) < 8) begin
            len = $urandom_range(1, 12);
            repeat (len) send_item($urandom_range(255), $urandom_range(15) == 0);
        end else begin
            len     = ($urandom_range(9) == 0) ? $urandom_range(60, 95) : $urandom_range(0, 20);
            sep_pct = ($urandom_range(3) == 0) ? 85 : 25;
            repeat (len) begin
                if ($urandom_range(99) < sep_pct) begin
                    b = cur_sep;
                end else begin
                    do b = $urandom_range(255); while (b == NL_BYTE);
                end
                send_item(b, 1'b0);
            end
            ending = $urandom_range(99);
            if (ending < 75) begin
                send_item(NL_BYTE, 1'b0);
            end else if (ending < 85) begin
                send_item(NL_BYTE, 1'b1);
            end else if (ending < 95) begin
                do b = $urandom_range(255); while (b == NL_BYTE);
                send_item(b, 1'b1);
            end
            // else: leave the line open so it runs into the next one
        end
    endtask

    initial begin
        int               target;
        int               phase_end;
        int               phase;
        int               pick;
        logic             cm;
        logic [BYTE_W-1:0] dl;
        logic [SEL_W-1:0] sel;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: only newlines get through
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(TAB_BYTE, 1'b0);
        send_item(NL_BYTE, 1'b0);

        // fields 1 and 3 of "a<tab>b<tab>c", then end of stream on a byte and on a newline
        configure(1'b0, TAB_BYTE, 64'h5);
        send_item(8'h61, 1'b0);
        send_item(TAB_BYTE, 1'b0);
        send_item(8'h62, 1'b0);
        send_item(TAB_BYTE, 1'b0);
        send_item(8'h63, 1'b0);
        send_item(NL_BYTE, 1'b0);
        send_item(8'h78, 1'b1);
        send_item(NL_BYTE, 1'b1);

        // character mode, first and last bitmap positions
        configure(1'b1, 8'h00, 64'h8000_0000_0000_0001);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);

        // zero byte as separator, empty fields all picked
        configure(1'b0, 8'h00, '1);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h41, 1'b1);

        // separator equal to newline: newline wins
        configure(1'b0, NL_BYTE, '1);
        send_item(8'h41, 1'b0);
        send_item(NL_BYTE, 1'b0);
        send_item(8'h42, 1'b0);

        // random phases, each with fresh settings
        target = item_count + RANDOM_ITEMS;
        phase  = 0;
        while (item_count < target) begin
            cm   = $urandom_range(1);
            pick = $urandom_range(9);
            case (pick)
                0:       dl = 8'h00;
                1:       dl = 8'hFF;
                2:       dl = NL_BYTE;
                3, 4, 5: dl = TAB_BYTE;
                default: dl = $urandom_range(255);
            endcase
            pick = $urandom_range(9);
            case (pick)
                0:       sel = '0;
                1:       sel = '1;
                2:       sel = 64'h8000_0000_0000_0000 | {$urandom, $urandom};
                3, 4:    sel = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
                default: sel = {$urandom, $urandom};
            endcase
            configure(cm, dl, sel);
            steady <= (phase == 2);
            phase_end = item_count + $urandom_range(60, 300);
            while (item_count < phase_end && item_count < target) begin
                send_line();
                if ($urandom_range(19) == 0) drain();
            end
            phase++;
        end

        steady <= 1'b0;
        drain();
        if (errors == 0)
            $display("delimited_field_selector_unit: match");
        else
            $display("delimited_field_selector_unit: mismatch");
        $finish;
    end

endmodule

[sim.f]
src/dfs_pkg.sv
src/dfs_front.sv
src/dfs_queue.sv
src/dfs_back.sv
src/delimited_field_selector_unit.sv
tb/dfs_checker.sv
tb/tb_top.sv
